[design/length_framed_display_command_parser_unit_assert.svh]
// ----------------------------------------------------------------------------
// length_framed_display_command_parser_unit_assert
// Assertion macros used by the top module of the command parser.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef LENGTH_FRAMED_DISPLAY_COMMAND_PARSER_UNIT_ASSERT_SVH
`define LENGTH_FRAMED_DISPLAY_COMMAND_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define LFDC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define LFDC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lfdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfdc_pkg
// Shared types, constants and the glyph lookup of the command parser.
// ----------------------------------------------------------------------------
package lfdc_pkg;

    localparam int MAX_FRAME_LEN_DEF = 1023;
    localparam int DIGIT_COUNT_DEF   = 4;

    // frame byte counter wraps at 1024
    localparam int CNT_W = 10;

    localparam int GLYPH_W     = 6;
    localparam int GLYPH_SLOTS = 4;
    localparam int OUT_DEPTH   = 3;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] KIND_INIT    = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE  = 6'd10;
    localparam logic [GLYPH_W-1:0] GLYPH_ABSENT = 6'd11;
    localparam logic [GLYPH_W-1:0] GLYPH_ALPHA  = 6'd12;

    localparam logic [7:0] LEVEL_MAX = 8'd255;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [3:0] INIT_LEN = 4'd10;
    localparam logic [3:0] DATA_LEN = 4'd4;
    localparam logic [3:0] KW_POS_MAX = 4'd15;

    localparam logic [7:0] KW_INIT [0:9] = '{"I", "n", "i", "t", "i", "a", "l", "i", "z", "e"};
    localparam logic [7:0] KW_DATA [0:3] = '{"D", "a", "t", "a"};

    typedef struct packed {
        logic [1:0]                            kind;
        logic [7:0]                            level;
        logic [GLYPH_SLOTS-1:0][GLYPH_W-1:0]   glyph;
    } lfdc_result_t;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] b);
        logic [GLYPH_W-1:0] g;
        g = GLYPH_ABSENT;
        if (b >= "0" && b <= "9")
        begin
            g = GLYPH_W'(b - "0");
        end
        else if (b == " ")
        begin
            g = GLYPH_SPACE;
        end
        else if (b >= "A" && b <= "Z")
        begin
            g = GLYPH_W'(b - "A") + GLYPH_ALPHA;
        end
        return g;
    endfunction

endpackage
`default_nettype wire

[design/length_framed_display_command_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_framed_display_command_parser_unit
// Parses a byte stream of decimal length lines, each followed by one
// "Command:Parameter" frame, into display command results.
// ----------------------------------------------------------------------------
// Usage
//   Input channel : in_valid / in_stall carry one rx_byte per request.
//   Output channel: out_valid / out_stall carry one result per finished
//                   frame (command_kind, init_level, four glyph indices).
//   A frame closes on a newline or when its byte count reaches the length
//   given on the preceding length line; that closing byte yields the result.
//   Path: a taken byte is held in the input register, the parser reads it
//   from there, and a result it closes is written to the result queue.
//   Throughput: one byte per cycle. The parse state is a few small
//   registers updated once per byte, so nothing limits the rate while the
//   receiver keeps up.
//   Stalling: finished results wait in a three-entry queue. in_stall rises
//   only when the queue plus the byte in flight could fill it, and is
//   driven from registers alone, so it never depends on out_stall in the
//   same cycle.
//   Reset (rst_n low, asynchronous): the parser expects a length line,
//   the queue is emptied and out_valid drops at once.
// ----------------------------------------------------------------------------
`include "length_framed_display_command_parser_unit_assert.svh"

module length_framed_display_command_parser_unit
    import lfdc_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int DIGIT_COUNT   = DIGIT_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 command_kind,
    output logic [7:0]                 init_level,
    output logic [GLYPH_W-1:0]         glyph_first,
    output logic [GLYPH_W-1:0]         glyph_second,
    output logic [GLYPH_W-1:0]         glyph_third,
    output logic [GLYPH_W-1:0]         glyph_fourth
);

    // input register: one byte in flight towards the parser
    logic                      byte_valid_reg;
    logic [7:0]                byte_reg;
    logic                      accept;

    logic                      res_valid;
    lfdc_result_t              res;
    lfdc_result_t              head;
    logic [OUT_CNT_W-1:0]      q_count;
    logic [OUT_CNT_W:0]        occupancy;

    // queued results plus the byte that may still close a frame
    assign occupancy = (OUT_CNT_W + 1)'(q_count) + (OUT_CNT_W + 1)'(byte_valid_reg);
    assign in_stall  = (occupancy >= (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= accept;
        end
    end

    // hold the byte while nothing new is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    lfdc_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .DIGIT_COUNT   (DIGIT_COUNT)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid_reg),
        .rx_byte    (byte_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    lfdc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (head),
        .count     (q_count)
    );

    assign command_kind = head.kind;
    assign init_level   = head.level;
    assign glyph_first  = head.glyph[0];
    assign glyph_second = head.glyph[1];
    assign glyph_third  = head.glyph[2];
    assign glyph_fourth = head.glyph[3];

    `LFDC_ASSERT_IMP(a_occ_bound, 1'b1, occupancy <= (OUT_CNT_W + 1)'(OUT_DEPTH), "result queue overrun")
    `LFDC_ASSERT_NXT(a_accept_loads, accept, byte_valid_reg, "accepted byte not loaded")
    `LFDC_ASSERT_IMP(a_kind_legal, out_valid, command_kind == KIND_INIT || command_kind == KIND_DATA || command_kind == KIND_UNKNOWN, "illegal command kind")
    `LFDC_ASSERT_IMP(a_data_level, out_valid && command_kind != KIND_INIT, init_level == 8'd0, "level set on non-initialize result")

endmodule
`default_nettype wire

[design/lfdc_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfdc_parser
// Per-byte parse state: length line, keyword match, parameter number and
// glyph capture. Raises one result request when a frame ends.
// ----------------------------------------------------------------------------
module lfdc_parser
    import lfdc_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int DIGIT_COUNT   = DIGIT_COUNT_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    rx_byte,
    output logic               res_valid,
    output lfdc_result_t       res
);

    localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);
    localparam int ACC_W = LEN_W + 4;
    localparam int PP_W  = $clog2(DIGIT_COUNT + 1);
    localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam logic [ACC_W-1:0] LEN_CAP = ACC_W'(MAX_FRAME_LEN);

    typedef enum logic [3:0] {
        PH_BEFORE = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    logic                 body_reg,    body_next;
    logic [LEN_W-1:0]     len_acc_reg, len_acc_next;
    logic [LEN_W-1:0]     exp_len_reg, exp_len_next;
    logic [CNT_W-1:0]     fcnt_reg,    fcnt_next;
    logic                 rd_par_reg,  rd_par_next;
    logic [1:0]           kw_flags_reg, kw_flags_next;
    logic [3:0]           kw_pos_reg,  kw_pos_next;
    logic [PP_W-1:0]      par_pos_reg, par_pos_next;
    logic [7:0]           num_reg,     num_next;
    phase_t               phase_reg,   phase_next;
    logic [GLYPH_W-1:0]   glyph_reg  [DIGIT_COUNT];
    logic [GLYPH_W-1:0]   glyph_next [DIGIT_COUNT];

    // values after this byte is taken into the frame
    logic                 t_rd_par;
    logic [1:0]           t_flags;
    logic [3:0]           t_kpos;
    logic [PP_W-1:0]      t_ppos;
    logic [7:0]           t_num;
    phase_t               t_phase;
    logic [GLYPH_W-1:0]   t_glyph    [DIGIT_COUNT];
    logic [GLYPH_W-1:0]   take_glyph [DIGIT_COUNT];
    logic [GLYPH_SLOTS-1:0][GLYPH_W-1:0] slots;

    logic                 is_lf;
    logic                 is_space;
    logic                 is_sign;
    logic                 is_digit;
    logic [3:0]           digit;
    logic                 feed_dig;
    phase_t               phase_fed;
    logic [ACC_W-1:0]     len_prod;
    logic [LEN_W-1:0]     len_fed;
    logic [11:0]          num_prod;
    logic [7:0]           num_fed;
    logic                 init_hit;
    logic                 data_hit;
    logic [CNT_W-1:0]     fcnt_inc;
    logic                 ends;

    assign is_lf    = (rx_byte == CHAR_LF);
    assign is_space = (rx_byte == " ") || (rx_byte >= 8'd9 && rx_byte <= 8'd13);
    assign is_sign  = (rx_byte == "+") || (rx_byte == "-");
    assign is_digit = (rx_byte >= "0") && (rx_byte <= "9");
    assign digit    = rx_byte[3:0];
    assign feed_dig = (phase_reg != PH_DONE) && is_digit;

    // number syntax shared by the length line and the initialize parameter
    always_comb
    begin
        if (phase_reg == PH_BEFORE && is_space)
        begin
            phase_fed = phase_reg;
        end
        else if (phase_reg == PH_BEFORE && is_sign)
        begin
            phase_fed = PH_SIGN;
        end
        else if (feed_dig)
        begin
            phase_fed = PH_DIGITS;
        end
        else
        begin
            phase_fed = PH_DONE;
        end
    end

    assign len_prod = (ACC_W'(len_acc_reg) << 3) + (ACC_W'(len_acc_reg) << 1) + ACC_W'(digit);
    assign len_fed  = !feed_dig ? len_acc_reg :
                      (len_prod > LEN_CAP) ? LEN_CAP[LEN_W-1:0] : len_prod[LEN_W-1:0];

    assign num_prod = (12'(num_reg) << 3) + (12'(num_reg) << 1) + 12'(digit);
    assign num_fed  = !feed_dig ? num_reg :
                      (num_prod > 12'(LEVEL_MAX)) ? LEVEL_MAX : num_prod[7:0];

    assign init_hit = (kw_pos_reg < INIT_LEN) && (KW_INIT[kw_pos_reg] == rx_byte);
    assign data_hit = (kw_pos_reg < DATA_LEN) && (KW_DATA[kw_pos_reg[1:0]] == rx_byte);

    assign fcnt_inc = fcnt_reg + CNT_W'(1);
    assign ends     = is_lf || (CMP_W'(fcnt_inc) == CMP_W'(exp_len_reg));

    generate
        for (genvar j = 0; j < DIGIT_COUNT; j++)
        begin : g_take
            assign take_glyph[j] = (par_pos_reg == PP_W'(j)) ? glyph_of(rx_byte) : glyph_reg[j];
        end
        for (genvar j = 0; j < GLYPH_SLOTS; j++)
        begin : g_slot
            if (j < DIGIT_COUNT)
            begin : g_live
                assign slots[j] = t_glyph[j];
            end
            else
            begin : g_pad
                assign slots[j] = GLYPH_ABSENT;
            end
        end
    endgenerate

    // take one frame byte (newline excluded)
    always_comb
    begin
        t_rd_par = rd_par_reg;
        t_flags  = kw_flags_reg;
        t_kpos   = kw_pos_reg;
        t_ppos   = par_pos_reg;
        t_num    = num_reg;
        t_phase  = phase_reg;
        t_glyph  = glyph_reg;
        if (!is_lf)
        begin
            if (!rd_par_reg)
            begin
                if (rx_byte == CHAR_COLON)
                begin
                    t_rd_par = 1'b1;
                end
                else
                begin
                    t_flags = {kw_flags_reg[1] & data_hit, kw_flags_reg[0] & init_hit};
                    t_kpos  = (kw_pos_reg == KW_POS_MAX) ? KW_POS_MAX : kw_pos_reg + 4'd1;
                end
            end
            else
            begin
                t_num   = num_fed;
                t_phase = phase_fed;
                if (par_pos_reg < PP_W'(DIGIT_COUNT))
                begin
                    t_glyph = take_glyph;
                    t_ppos  = par_pos_reg + PP_W'(1);
                end
            end
        end
    end

    // result of a frame that ends on this byte
    always_comb
    begin
        res = '0;
        if (t_flags[0] && t_kpos == INIT_LEN)
        begin
            res.kind  = KIND_INIT;
            res.level = t_num;
        end
        else if (t_flags[1] && t_kpos == DATA_LEN)
        begin
            res.kind  = KIND_DATA;
            res.glyph = slots;
        end
        else
        begin
            res.kind = KIND_UNKNOWN;
        end
    end

    always_comb
    begin
        body_next     = body_reg;
        len_acc_next  = len_acc_reg;
        exp_len_next  = exp_len_reg;
        fcnt_next     = fcnt_reg;
        rd_par_next   = rd_par_reg;
        kw_flags_next = kw_flags_reg;
        kw_pos_next   = kw_pos_reg;
        par_pos_next  = par_pos_reg;
        num_next      = num_reg;
        phase_next    = phase_reg;
        glyph_next    = glyph_reg;
        res_valid     = 1'b0;
        if (byte_valid)
        begin
            if (!body_reg)
            begin
                if (is_lf)
                begin
                    // length line done: open the frame with a clean parse
                    body_next     = 1'b1;
                    exp_len_next  = len_acc_reg;
                    len_acc_next  = '0;
                    fcnt_next     = '0;
                    rd_par_next   = 1'b0;
                    kw_flags_next = 2'b11;
                    kw_pos_next   = '0;
                    par_pos_next  = '0;
                    num_next      = '0;
                    phase_next    = PH_BEFORE;
                    for (int i = 0; i < DIGIT_COUNT; i++)
                    begin
                        glyph_next[i] = GLYPH_ABSENT;
                    end
                end
                else
                begin
                    len_acc_next = len_fed;
                    phase_next   = phase_fed;
                end
            end
            else if (ends)
            begin
                res_valid     = 1'b1;
                body_next     = 1'b0;
                len_acc_next  = '0;
                fcnt_next     = '0;
                rd_par_next   = 1'b0;
                kw_flags_next = 2'b11;
                kw_pos_next   = '0;
                par_pos_next  = '0;
                num_next      = '0;
                phase_next    = PH_BEFORE;
                for (int i = 0; i < DIGIT_COUNT; i++)
                begin
                    glyph_next[i] = GLYPH_ABSENT;
                end
            end
            else
            begin
                fcnt_next     = fcnt_inc;
                rd_par_next   = t_rd_par;
                kw_flags_next = t_flags;
                kw_pos_next   = t_kpos;
                par_pos_next  = t_ppos;
                num_next      = t_num;
                phase_next    = t_phase;
                glyph_next    = t_glyph;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_reg     <= 1'b0;
            len_acc_reg  <= '0;
            exp_len_reg  <= '0;
            fcnt_reg     <= '0;
            rd_par_reg   <= 1'b0;
            kw_flags_reg <= 2'b11;
            kw_pos_reg   <= '0;
            par_pos_reg  <= '0;
            num_reg      <= '0;
            phase_reg    <= PH_BEFORE;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                glyph_reg[i] <= GLYPH_ABSENT;
            end
        end
        else
        begin
            body_reg     <= body_next;
            len_acc_reg  <= len_acc_next;
            exp_len_reg  <= exp_len_next;
            fcnt_reg     <= fcnt_next;
            rd_par_reg   <= rd_par_next;
            kw_flags_reg <= kw_flags_next;
            kw_pos_reg   <= kw_pos_next;
            par_pos_reg  <= par_pos_next;
            num_reg      <= num_next;
            phase_reg    <= phase_next;
            glyph_reg    <= glyph_next;
        end
    end

endmodule
`default_nettype wire

[design/lfdc_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfdc_out_fifo
// Small result queue that holds finished requests while the receiver stalls.
// ----------------------------------------------------------------------------
module lfdc_out_fifo
    import lfdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lfdc_result_t          push_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output lfdc_result_t               out_data,
    output logic [OUT_CNT_W-1:0]       count
);

    lfdc_result_t              entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]      cnt_reg,    cnt_next;
    logic                      pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = cnt_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : wr_ptr_reg + OUT_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : rd_ptr_reg + OUT_PTR_W'(1);
        end
        cnt_next = cnt_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[sim/length_framed_display_command_parser_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_framed_display_command_parser_unit_tb
// Feeds length lines and "Command:Parameter" frames to the parser, one byte
// per request. A shadow parser works out each result from the accepted
// bytes, and every result taken at the output is checked against the oldest
// one waiting. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module length_framed_display_command_parser_unit_tb;
    import lfdc_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_BYTES     = 860;
    localparam int HOLD_TRIGGER     = 25;
    localparam int LONG_HOLD_CYCLES = 1000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int DRAIN_MARK       = -1;

    localparam logic [8*10-1:0] INIT_WORD = "Initialize";
    localparam logic [8*4-1:0]  DATA_WORD = "Data";

    typedef enum logic [1:0] {
        NUM_LEAD,
        NUM_SIGNED,
        NUM_DIGITS,
        NUM_DONE
    } num_state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         level;
        logic [GLYPH_W-1:0] g0, g1, g2, g3;
    } display_cmd_t;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte   = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         command_kind;
    logic [7:0]         init_level;
    logic [GLYPH_W-1:0] glyph_first;
    logic [GLYPH_W-1:0] glyph_second;
    logic [GLYPH_W-1:0] glyph_third;
    logic [GLYPH_W-1:0] glyph_fourth;

    length_framed_display_command_parser_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command_kind (command_kind),
        .init_level   (init_level),
        .glyph_first  (glyph_first),
        .glyph_second (glyph_second),
        .glyph_third  (glyph_third),
        .glyph_fourth (glyph_fourth)
    );

    // ------------------------------------------------------------------------
    // Shadow parser state, kept at the widths of the block
    // ------------------------------------------------------------------------
    logic               body_open;
    logic [9:0]         len_acc;
    logic [9:0]         len_goal;
    logic [9:0]         frame_cnt;
    logic               past_colon;
    logic [1:0]         kw_alive;       // bit 0 Initialize, bit 1 Data
    logic [3:0]         kw_idx;
    logic [2:0]         param_idx;
    logic [7:0]         level_acc;
    num_state_t         num_state;
    logic [GLYPH_W-1:0] glyph_shadow [0:3];

    // Results still owed by the block, oldest first
    display_cmd_t expected_cmds[$];
    display_cmd_t want;

    // Bytes still to be offered; DRAIN_MARK makes the sender wait for the
    // output to catch up before it carries on
    int          rx_backlog[$];
    logic [7:0]  frame_text[$];
    int          sent_count    = 0;

    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          cycle_count    = 0;
    logic        req_taken      = 1'b0;

    // sender pacing
    int          gap_left       = 0;
    int          send_steady    = 0;
    bit          draining       = 1'b0;
    int          next_word;

    // receiver pacing
    int          stall_left     = 0;
    int          recv_steady    = 0;
    int          long_hold_left = 0;
    bit          long_hold_done = 1'b0;

    // ------------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------------
    function automatic bit is_blank(input logic [7:0] b);
        return (b == " ") || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_code(input logic [7:0] b);
        if (b >= "0" && b <= "9")
        begin
            return GLYPH_W'(b - "0");
        end
        if (b >= "A" && b <= "Z")
        begin
            return GLYPH_ALPHA + GLYPH_W'(b - "A");
        end
        return (b == " ") ? GLYPH_SPACE : GLYPH_ABSENT;
    endfunction

    // Fold one byte into a decimal number: skip leading blanks, swallow one
    // sign, accumulate digits up to cap, freeze on anything else.
    task automatic fold_number(inout int unsigned acc, input logic [7:0] b,
                               input int unsigned cap);
        if (num_state == NUM_LEAD && (b == "+" || b == "-"))
        begin
            num_state = NUM_SIGNED;
        end
        else if (num_state != NUM_DONE && b >= "0" && b <= "9")
        begin
            num_state = NUM_DIGITS;
            acc = acc * 10 + (b - "0");
            if (acc > cap)
            begin
                acc = cap;
            end
        end
        else if (!(num_state == NUM_LEAD && is_blank(b)))
        begin
            num_state = NUM_DONE;
        end
    endtask

    task automatic restart_frame();
        int k;
        past_colon = 1'b0;
        kw_alive   = 2'b11;
        kw_idx     = 4'd0;
        param_idx  = 3'd0;
        level_acc  = 8'd0;
        num_state  = NUM_LEAD;
        for (k = 0; k < 4; k++)
        begin
            glyph_shadow[k] = GLYPH_ABSENT;
        end
    endtask

    task automatic restart_parser();
        body_open = 1'b0;
        len_acc   = 10'd0;
        len_goal  = 10'd0;
        frame_cnt = 10'd0;
        restart_frame();
    endtask

    // One byte of frame body that is not the closing newline
    task automatic take_body_byte(input logic [7:0] b);
        int          k;
        int unsigned acc;
        if (!past_colon)
        begin
            if (b == CHAR_COLON)
            begin
                past_colon = 1'b1;
            end
            else
            begin
                k = kw_idx;
                if (k >= 10 || INIT_WORD[8*(9-k) +: 8] != b)
                begin
                    kw_alive[0] = 1'b0;
                end
                if (k >= 4 || DATA_WORD[8*(3-k) +: 8] != b)
                begin
                    kw_alive[1] = 1'b0;
                end
                if (kw_idx != KW_POS_MAX)
                begin
                    kw_idx = kw_idx + 4'd1;
                end
            end
        end
        else
        begin
            acc = level_acc;
            fold_number(acc, b, LEVEL_MAX);
            level_acc = acc[7:0];
            if (param_idx < DIGIT_COUNT_DEF)
            begin
                glyph_shadow[param_idx[1:0]] = glyph_code(b);
                param_idx = param_idx + 3'd1;
            end
        end
    endtask

    // Advance the shadow parser by one accepted byte and queue the result
    // that the byte closes, if any.
    task automatic parse_rx_byte(input logic [7:0] b);
        int unsigned  acc;
        logic         closes;
        display_cmd_t cmd;
        if (!body_open)
        begin
            if (b == CHAR_LF)
            begin
                len_goal  = len_acc;
                len_acc   = 10'd0;
                frame_cnt = 10'd0;
                body_open = 1'b1;
                restart_frame();
            end
            else
            begin
                acc = len_acc;
                fold_number(acc, b, MAX_FRAME_LEN_DEF);
                len_acc = acc[9:0];
            end
        end
        else
        begin
            frame_cnt = frame_cnt + 10'd1;
            closes = (b == CHAR_LF) || (frame_cnt == len_goal);
            if (b != CHAR_LF)
            begin
                take_body_byte(b);
            end
            if (closes)
            begin
                cmd = '0;
                if (kw_alive[0] && kw_idx == INIT_LEN)
                begin
                    cmd.kind  = KIND_INIT;
                    cmd.level = level_acc;
                end
                else if (kw_alive[1] && kw_idx == DATA_LEN)
                begin
                    cmd.kind = KIND_DATA;
                    cmd.g0   = glyph_shadow[0];
                    cmd.g1   = glyph_shadow[1];
                    cmd.g2   = glyph_shadow[2];
                    cmd.g3   = glyph_shadow[3];
                end
                else
                begin
                    cmd.kind = KIND_UNKNOWN;
                end
                expected_cmds.push_back(cmd);
                body_open = 1'b0;
                len_acc   = 10'd0;
                frame_cnt = 10'd0;
                restart_frame();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= CHAR_LF)
        begin
            b = b + 8'd1;
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return " ";
            1:       return 8'h09;
            2:       return 8'h0B;
            3:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        b = any_but_lf();
        if (b >= "0" && b <= "9")
        begin
            b = "x";
        end
        return b;
    endfunction

    // Mostly characters that have a glyph, with some that do not
    function automatic logic [7:0] glyph_char();
        case ($urandom_range(0, 5))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return " ";
            2, 3:    return 8'("A" + $urandom_range(0, 25));
            4:       return ($urandom_range(0, 1) != 0) ? CHAR_COLON : "*";
            default: return any_but_lf();
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        rx_backlog.push_back({24'd0, b});
        sent_count++;
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
        begin
            send_byte(s[k]);
        end
    endtask

    task automatic stage_byte(input logic [7:0] b);
        frame_text.push_back(b);
    endtask

    task automatic stage_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
        begin
            stage_byte(s[k]);
        end
    endtask

    // Length line for value, dressed up now and then with blanks, a sign,
    // leading zeros or trailing junk that the number syntax must ignore
    task automatic send_length_line(input int unsigned value);
        if (value == 0 && $urandom_range(0, 3) == 0)
        begin
            send_byte(CHAR_LF);
        end
        else
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_byte(pick_blank());
            end
            if ($urandom_range(0, 5) == 0)
            begin
                send_byte(($urandom_range(0, 1) != 0) ? "+" : "-");
            end
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_byte("0");
            end
            send_text($sformatf("%0d", value));
            if ($urandom_range(0, 5) == 0)
            begin
                send_byte(non_digit());
                repeat ($urandom_range(0, 3)) send_byte(any_but_lf());
            end
            send_byte(CHAR_LF);
        end
    endtask

    task automatic stage_init_frame();
        int unsigned v;
        if ($urandom_range(0, 9) == 0)
        begin
            stage_text("Initialize");
        end
        else
        begin
            stage_text("Initialize:");
            if ($urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 2)) stage_byte(pick_blank());
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    stage_byte(($urandom_range(0, 1) != 0) ? "+" : "-");
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    repeat ($urandom_range(1, 2)) stage_byte("0");
                end
                case ($urandom_range(0, 3))
                    0, 1:    v = $urandom_range(0, 255);
                    2:       v = $urandom_range(256, 999);
                    default: v = $urandom_range(1000, 99999);
                endcase
                stage_text($sformatf("%0d", v));
                if ($urandom_range(0, 4) == 0)
                begin
                    stage_byte(non_digit());
                    repeat ($urandom_range(0, 3)) stage_byte(any_but_lf());
                end
            end
            else
            begin
                repeat ($urandom_range(0, 4)) stage_byte(any_but_lf());
            end
        end
    endtask

    task automatic stage_data_frame();
        stage_text("Data:");
        repeat ($urandom_range(0, 6)) stage_byte(glyph_char());
    endtask

    // Near misses of the keywords, bare keywords and plain junk
    task automatic stage_odd_command();
        case ($urandom_range(0, 11))
            0:       stage_text("Initializ");
            1:       stage_text("Initializee");
            2:       stage_text("nitialize");
            3:       stage_text("Initialise");
            4:       stage_text("Dat");
            5:       stage_text("Datas");
            6:       stage_text("data");
            7:       stage_text("DATA");
            8:       stage_text("Data");
            default: repeat ($urandom_range(0, 20)) stage_byte(any_but_lf());
        endcase
        if ($urandom_range(0, 1) != 0)
        begin
            stage_byte(CHAR_COLON);
            repeat ($urandom_range(0, 5)) stage_byte(glyph_char());
        end
    endtask

    // Send the staged frame, closed either by its byte count or by a
    // newline under a length that cannot close it first
    task automatic emit_frame(input bit by_count);
        int unsigned goal;
        int          k;
        if (frame_text.size() == 0)
        begin
            by_count = 1'b0;
        end
        if (by_count)
        begin
            goal = frame_text.size();
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       goal = 0;
                1:       goal = frame_text.size() + 1;
                2:       goal = frame_text.size() + 1 + $urandom_range(0, 60);
                default: goal = $urandom_range(MAX_FRAME_LEN_DEF, 99999);
            endcase
        end
        send_length_line(goal);
        for (k = 0; k < frame_text.size(); k++)
        begin
            send_byte(frame_text[k]);
        end
        if (!by_count)
        begin
            send_byte(CHAR_LF);
        end
        frame_text.delete();
    endtask

    task automatic report_field(input string field, input int unsigned exp_val,
                                input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_cmds.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge, check results, then predict from
    // the request taken at the same edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            restart_parser();
            req_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual kind %0d level %0d",
                             $time, command_kind, init_level);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    report_field("command_kind", want.kind, command_kind);
                    report_field("init_level", want.level, init_level);
                    report_field("glyph_first", want.g0, glyph_first);
                    report_field("glyph_second", want.g1, glyph_second);
                    report_field("glyph_third", want.g2, glyph_third);
                    report_field("glyph_fourth", want.g3, glyph_fourth);
                end
            end
            if (in_valid && !in_stall)
            begin
                parse_rx_byte(rx_byte);
            end
            req_taken <= in_valid && !in_stall;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Hold a request until it is
    // taken, then idle for a random gap or offer the next byte straight away.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || req_taken)
        begin
            if (draining)
            begin
                // pause the sender until every owed result has been taken
                in_valid <= 1'b0;
                if (expected_cmds.size() == 0)
                begin
                    draining = 1'b0;
                end
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (rx_backlog.size() != 0)
            begin
                next_word = rx_backlog.pop_front();
                if (next_word == DRAIN_MARK)
                begin
                    in_valid <= 1'b0;
                    draining = 1'b1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= next_word[7:0];
                    if (send_steady > 0)
                    begin
                        send_steady--;
                    end
                    else if ($urandom_range(0, 99) < 3)
                    begin
                        send_steady = $urandom_range(30, 90);
                    end
                    else
                    begin
                        gap_left = idle_length();
                    end
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, stretches without any, and one long hold-off
    // so that the result queue fills and the block stalls its input
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (!long_hold_done && results_seen >= HOLD_TRIGGER)
            begin
                long_hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (long_hold_left > 0)
            begin
                out_stall <= 1'b1;
                long_hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (recv_steady > 0)
                begin
                    recv_steady--;
                end
                else if ($urandom_range(0, 99) < 4)
                begin
                    recv_steady = $urandom_range(40, 120);
                end
                else
                begin
                    stall_left = idle_length();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int frames;
        int random_start;
        int k;

        // Directed: saturation of level and length, number syntax, both
        // ways of closing a frame, glyph classes, keyword near misses
        send_text("14\nInitialize:255");
        send_text(" \t+0020\nInitialize:+0300\n");
        send_text("99999\nInitialize: -7x9\n");
        send_text("\nInitialize:\n");
        send_text("10\nInitialize");
        send_text("9\nData:09 Z");
        send_text("30\nData:AZ*a\n");
        send_text("6\nData:1");
        send_text("12x4\nData:12345:\n");
        send_text("4\nData");
        send_text("40\nInitializ:5\n");
        send_text("40\ndata:12\n");
        send_text("40\nInitialize");
        send_byte(8'h00);
        send_text(":1\n");
        send_text("40\nFoo:Bar:Baz\n");
        rx_backlog.push_back(DRAIN_MARK);

        // Random: mostly well-formed frames, with some raw noise
        frames = 0;
        random_start = sent_count;
        while (sent_count < random_start + RANDOM_BYTES)
        begin
            k = $urandom_range(0, 99);
            if (k < 92)
            begin
                if (k < 38)
                begin
                    stage_init_frame();
                end
                else if (k < 72)
                begin
                    stage_data_frame();
                end
                else
                begin
                    stage_odd_command();
                end
                emit_frame($urandom_range(0, 1));
                frames++;
                if (frames == 20 || frames == 45)
                begin
                    rx_backlog.push_back(DRAIN_MARK);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (rx_backlog.size() != 0 || in_valid || draining || expected_cmds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_cmds.size() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time, expected_cmds.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/lfdc_pkg.sv
design/lfdc_parser.sv
design/lfdc_out_fifo.sv
design/length_framed_display_command_parser_unit.sv
sim/length_framed_display_command_parser_unit_tb.sv
